FILE: hdl/wrmd_pkg.sv
// Shared types, constants and the square-root step for the rigid-motion displacement block.
package wrmd_pkg;

   localparam int GRID_MAX_DEF     = 64;
   localparam int WEIGHT_DEPTH_DEF = 262144;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOX_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOX_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOX_Z  = 3'd5;
   localparam logic [6:0]  GRID_RESET = 7'd64;
   localparam logic [15:0] VOX_RESET  = 16'd4096;

   // Request kinds carried in req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Request tdata layout.
   localparam int REQ_TDATA_W = 176;
   localparam int F_ADDR_LSB  = 0;
   localparam int F_WVAL_LSB  = 18;
   localparam int F_REC_LSB   = 34;
   localparam int F_QX_LSB    = 50;
   localparam int F_QY_LSB    = 66;
   localparam int F_QZ_LSB    = 82;
   localparam int F_WNEG_LSB  = 98;
   localparam int F_SX_LSB    = 99;
   localparam int F_SY_LSB    = 123;
   localparam int F_SZ_LSB    = 147;

   // Response tdata layout.
   localparam int RSP_TDATA_W  = 80;
   localparam int RSP_IDX_LSB  = 0;
   localparam int RSP_TLEN_LSB = 16;
   localparam int RSP_MEAN_LSB = 48;

   localparam int SQRT_STAGES = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_SUM,
      ST_TSQ,
      ST_ROOT_W,
      ST_ROOT_T,
      ST_WAIT,
      ST_S2,
      ST_WALK,
      ST_DRAIN,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SQ_NONE,
      SQ_VOXEL,
      SQ_WQ,
      SQ_TLEN
   } sqtag_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_stage_type;

   // One digit of a restoring square root: two radicand bits in, one root bit out.
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type cur);
      sqrt_stage_type nxt;
      logic [35:0] rem2;
      logic [35:0] trial;
      rem2 = {cur.rem[33:0], cur.rad[63:62]};
      trial = {2'b00, cur.root, 2'b01};
      nxt.rad = {cur.rad[61:0], 2'b00};
      if (rem2 >= trial) begin
         nxt.rem = rem2 - trial;
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem = rem2;
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

FILE: hdl/weighted_rigid_motion_displacement.sv
// Weighted rigid-motion displacement: weight memory, voxel walk pipeline and result sequencer.
//
//   channel   direction  contents
//   req_*     in         weight write or motion record to evaluate (tuser = kind)
//   rsp_*     out        index, translation length, mean displacement (tuser = zero weight)
//   csr_*     in         grid sizes and voxel sizes, write only
//
// A weight write leaves the block ready for the next request. An evaluation walks nx*ny*nz
// voxels after setup through the shared 32-stage square-root pipeline; the walk reads one voxel
// weight per cycle from the weight memory and is followed by a pipeline drain and a restoring
// divider. Reset is synchronous and restores the grid and voxel-size registers; the weight
// memory is not cleared. A stalled result holds in its output register while the block keeps
// taking transactions; a second result waits in the last state until the register is free.
module weighted_rigid_motion_displacement #(
   parameter int GRID_MAX     = wrmd_pkg::GRID_MAX_DEF,
   parameter int WEIGHT_DEPTH = wrmd_pkg::WEIGHT_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // weight_address, weight_value, record_index, quat_x, quat_y, quat_z, w_negative,
   // shift_x, shift_y, shift_z, zero fill
   input  logic [wrmd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,   // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_index, translation_length, mean_displacement
   output logic [wrmd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser,   // zero_weight
   input  logic                               csr_wen,
   input  logic [wrmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wrmd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int GW  = $clog2(GRID_MAX + 1);
   localparam int OW  = GW + 1;
   localparam int PW  = OW + 17;
   localparam int UPW = PW + 16;
   localparam int RW  = PW + 40;
   localparam int DW  = PW + 8;
   localparam int AW  = $clog2(WEIGHT_DEPTH);
   localparam int LW  = 3 * GW;
   localparam int WSW = LW + 16;
   localparam int SQN = wrmd_pkg::SQRT_STAGES;

   // Configuration.
   logic [6:0]  grid_ff [3];
   logic [15:0] vox_ff [3];
   logic [GW-1:0] n_size [3];

   // Control.
   wrmd_pkg::state_type state_ff, state_in;
   logic req_acc, mem_wr, issue, out_load, busy, grid_empty, walk_last;
   wrmd_pkg::sqtag_type inj_tag;
   logic [63:0] inj_rad;

   // Record capture and setup.
   logic signed [15:0] qu_ff [3];
   logic        wneg_ff;
   logic [23:0] smag_ff [3];
   logic [15:0] rec_ff;
   logic [30:0] sqp_ff [3];
   logic [39:0] tp_ff [3];
   logic [27:0] t_ff [3];
   logic [55:0] tq_ff [3];
   logic [31:0] s_ff;
   logic [63:0] tsq_ff;
   logic signed [16:0] wq_ff;
   logic [31:0] tlen_ff;
   logic signed [33:0] s2_ff;
   logic signed [31:0] sqp_in [3];
   logic signed [33:0] wsq_in;

   // Weight memory.
   logic [15:0] weight_mem [WEIGHT_DEPTH];
   logic [15:0] rd_ff;
   logic [31:0] waddr32, ridx32;

   // Walk counters and pipeline.
   logic [GW-1:0] ci_ff, cj_ff, ck_ff;
   logic [LW-1:0] idx_ff;
   logic [7:0]    vld_ff;
   logic          inr_ff;
   logic signed [OW-1:0]  off_ff [3];
   logic signed [OW-1:0]  off_in [3];
   logic [15:0]           wt_ff [1:7];
   logic signed [PW-1:0]  p_ff [3];
   logic signed [PW-1:0]  pc_ff [3];
   logic signed [PW-1:0]  pd_ff [3];
   logic signed [PW-1:0]  pe_ff [3];
   logic signed [UPW-1:0] dd_ff [3];
   logic signed [UPW-1:0] cxa_ff [3];
   logic signed [UPW-1:0] cxb_ff [3];
   logic signed [UPW+1:0] dot_ff;
   logic signed [UPW:0]   cr_ff [3];
   logic signed [PW+33:0] m1_ff [3];
   logic signed [UPW+17:0] m2_ff [3];
   logic signed [UPW+17:0] m3_ff [3];
   logic signed [RW-1:0]  r_in [3];
   logic [RW-1:0]         magr_in [3];
   logic [DW-1:0]         d_ff [3];
   logic [2*DW-1:0]       dprod_in [3];
   logic [63:0]           dq_ff [3];
   logic [63:0]           dsq_ff;

   // Square-root pipeline.
   wrmd_pkg::sqrt_stage_type sq_ff [SQN];
   wrmd_pkg::sqrt_stage_type sq_init;
   wrmd_pkg::sqtag_type      sqtag_ff [SQN];
   logic [15:0]              sqwt_ff [SQN];
   logic                     sq_busy;

   // Accumulation and division.
   logic        vi_ff;
   logic [47:0] term_ff;
   logic [15:0] wti_ff;
   logic [63:0] dsum_ff;
   logic [WSW-1:0] wsum_ff;
   logic [64:0] dsum65_in;
   logic [63:0] div_q_ff;
   logic [WSW-1:0] div_rem_ff;
   logic [5:0]  div_cnt_ff;
   logic [WSW:0] rem_sh_in;
   logic        div_ge;

   // Output register.
   logic        rspv_ff;
   logic [15:0] out_idx_ff;
   logic [31:0] out_tlen_ff, out_mean_ff;
   logic        out_zero_ff;
   logic [31:0] q32_in, mean_in;
   logic [32:0] m33_in;

   // ------------------------------------------------------------------
   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            grid_ff[a] <= wrmd_pkg::GRID_RESET;
            vox_ff[a] <= wrmd_pkg::VOX_RESET;
         end
      end else if (csr_wen) begin
         unique case (csr_index)
            wrmd_pkg::CSR_GRID_X: grid_ff[0] <= csr_wdata[6:0];
            wrmd_pkg::CSR_GRID_Y: grid_ff[1] <= csr_wdata[6:0];
            wrmd_pkg::CSR_GRID_Z: grid_ff[2] <= csr_wdata[6:0];
            wrmd_pkg::CSR_VOX_X:  vox_ff[0] <= csr_wdata;
            wrmd_pkg::CSR_VOX_Y:  vox_ff[1] <= csr_wdata;
            wrmd_pkg::CSR_VOX_Z:  vox_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (32'(grid_ff[a]) > 32'(GRID_MAX)) begin
            n_size[a] = GW'(GRID_MAX);
         end else begin
            n_size[a] = GW'(grid_ff[a]);
         end
      end
   end

   assign grid_empty = (n_size[0] == '0) || (n_size[1] == '0) || (n_size[2] == '0);
   assign walk_last = (ci_ff == n_size[0] - GW'(1)) && (cj_ff == n_size[1] - GW'(1))
                      && (ck_ff == n_size[2] - GW'(1));

   // ------------------------------------------------------------------
   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrmd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrmd_pkg::ST_IDLE: begin
            if (req_acc && req_tuser == wrmd_pkg::OP_EVAL) begin
               state_in = wrmd_pkg::ST_PROD;
            end
         end
         wrmd_pkg::ST_PROD:   state_in = wrmd_pkg::ST_SUM;
         wrmd_pkg::ST_SUM:    state_in = wrmd_pkg::ST_TSQ;
         wrmd_pkg::ST_TSQ:    state_in = wrmd_pkg::ST_ROOT_W;
         wrmd_pkg::ST_ROOT_W: state_in = wrmd_pkg::ST_ROOT_T;
         wrmd_pkg::ST_ROOT_T: state_in = wrmd_pkg::ST_WAIT;
         wrmd_pkg::ST_WAIT: begin
            if (sqtag_ff[SQN-1] == wrmd_pkg::SQ_TLEN) begin
               state_in = wrmd_pkg::ST_S2;
            end
         end
         wrmd_pkg::ST_S2: begin
            state_in = grid_empty ? wrmd_pkg::ST_DRAIN : wrmd_pkg::ST_WALK;
         end
         wrmd_pkg::ST_WALK: begin
            if (walk_last) begin
               state_in = wrmd_pkg::ST_DRAIN;
            end
         end
         wrmd_pkg::ST_DRAIN: begin
            if (!busy) begin
               state_in = (wsum_ff == '0) ? wrmd_pkg::ST_OUT : wrmd_pkg::ST_DIV;
            end
         end
         wrmd_pkg::ST_DIV: begin
            if (div_cnt_ff == 6'd63) begin
               state_in = wrmd_pkg::ST_OUT;
            end
         end
         wrmd_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = wrmd_pkg::ST_IDLE;
            end
         end
         default: state_in = wrmd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == wrmd_pkg::ST_IDLE);
      issue = (state_ff == wrmd_pkg::ST_WALK);
      out_load = (state_ff == wrmd_pkg::ST_OUT) && (!rspv_ff || rsp_tready);
      inj_tag = wrmd_pkg::SQ_NONE;
      inj_rad = dsq_ff;
      unique case (state_ff)
         wrmd_pkg::ST_ROOT_W: begin
            inj_tag = wrmd_pkg::SQ_WQ;
            inj_rad = (s_ff < 32'h4000_0000) ? 64'(32'h4000_0000 - s_ff) : 64'd0;
         end
         wrmd_pkg::ST_ROOT_T: begin
            inj_tag = wrmd_pkg::SQ_TLEN;
            inj_rad = tsq_ff;
         end
         default: begin
            if (vld_ff[7]) begin
               inj_tag = wrmd_pkg::SQ_VOXEL;
            end
         end
      endcase
   end

   assign req_acc = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Record capture and setup arithmetic.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sqp_in[a] = qu_ff[a] * qu_ff[a];
      end
      wsq_in = wq_ff * wq_ff;
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == wrmd_pkg::OP_EVAL) begin
         rec_ff <= req_tdata[wrmd_pkg::F_REC_LSB +: 16];
         qu_ff[0] <= $signed(req_tdata[wrmd_pkg::F_QX_LSB +: 16]);
         qu_ff[1] <= $signed(req_tdata[wrmd_pkg::F_QY_LSB +: 16]);
         qu_ff[2] <= $signed(req_tdata[wrmd_pkg::F_QZ_LSB +: 16]);
         wneg_ff <= req_tdata[wrmd_pkg::F_WNEG_LSB];
         smag_ff[0] <= req_tdata[wrmd_pkg::F_SX_LSB + 23]
                       ? 24'(-req_tdata[wrmd_pkg::F_SX_LSB +: 24])
                       : req_tdata[wrmd_pkg::F_SX_LSB +: 24];
         smag_ff[1] <= req_tdata[wrmd_pkg::F_SY_LSB + 23]
                       ? 24'(-req_tdata[wrmd_pkg::F_SY_LSB +: 24])
                       : req_tdata[wrmd_pkg::F_SY_LSB +: 24];
         smag_ff[2] <= req_tdata[wrmd_pkg::F_SZ_LSB + 23]
                       ? 24'(-req_tdata[wrmd_pkg::F_SZ_LSB +: 24])
                       : req_tdata[wrmd_pkg::F_SZ_LSB +: 24];
      end
      if (state_ff == wrmd_pkg::ST_PROD) begin
         for (int a = 0; a < 3; a++) begin
            sqp_ff[a] <= sqp_in[a][30:0];
            tp_ff[a] <= 40'(smag_ff[a]) * 40'(vox_ff[a]);
         end
      end
      if (state_ff == wrmd_pkg::ST_SUM) begin
         s_ff <= 32'(sqp_ff[0]) + 32'(sqp_ff[1]) + 32'(sqp_ff[2]);
         for (int a = 0; a < 3; a++) begin
            t_ff[a] <= tp_ff[a][39:12];
         end
      end
      if (state_ff == wrmd_pkg::ST_TSQ) begin
         for (int a = 0; a < 3; a++) begin
            tq_ff[a] <= t_ff[a] * t_ff[a];
         end
      end
      if (state_ff == wrmd_pkg::ST_ROOT_W) begin
         tsq_ff <= 64'(tq_ff[0]) + 64'(tq_ff[1]) + 64'(tq_ff[2]);
      end
      if (sqtag_ff[SQN-1] == wrmd_pkg::SQ_WQ) begin
         wq_ff <= wneg_ff ? -$signed({1'b0, sq_ff[SQN-1].root[15:0]})
                          : $signed({1'b0, sq_ff[SQN-1].root[15:0]});
      end
      if (sqtag_ff[SQN-1] == wrmd_pkg::SQ_TLEN) begin
         tlen_ff <= sq_ff[SQN-1].root;
      end
      if (state_ff == wrmd_pkg::ST_S2) begin
         s2_ff <= wsq_in - $signed({2'b00, s_ff});
      end
   end

   // ------------------------------------------------------------------
   // Weight memory: written by weight transactions, read once per walked voxel.
   assign waddr32 = 32'(req_tdata[wrmd_pkg::F_ADDR_LSB +: 18]);
   assign ridx32 = 32'(idx_ff);
   assign mem_wr = req_acc && (req_tuser == wrmd_pkg::OP_WRITE)
                   && (waddr32 < 32'(WEIGHT_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         weight_mem[waddr32[AW-1:0]] <= req_tdata[wrmd_pkg::F_WVAL_LSB +: 16];
      end
      if (issue) begin
         rd_ff <= weight_mem[ridx32[AW-1:0]];
      end
   end

   // ------------------------------------------------------------------
   // Voxel walk: x fastest, then y, then z; the linear index follows along.
   always_ff @(posedge clock) begin
      if (state_ff == wrmd_pkg::ST_S2) begin
         ci_ff <= '0;
         cj_ff <= '0;
         ck_ff <= '0;
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + LW'(1);
         if (ci_ff == n_size[0] - GW'(1)) begin
            ci_ff <= '0;
            if (cj_ff == n_size[1] - GW'(1)) begin
               cj_ff <= '0;
               ck_ff <= ck_ff + GW'(1);
            end else begin
               cj_ff <= cj_ff + GW'(1);
            end
         end else begin
            ci_ff <= ci_ff + GW'(1);
         end
      end
   end

   always_comb begin
      off_in[0] = $signed({1'b0, ci_ff}) - $signed({1'b0, n_size[0] >> 1});
      off_in[1] = $signed({1'b0, cj_ff}) - $signed({1'b0, n_size[1] >> 1});
      off_in[2] = $signed({1'b0, ck_ff}) - $signed({1'b0, n_size[2] >> 1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], issue};
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         r_in[a] = RW'(m1_ff[a]) + (RW'(m2_ff[a]) <<< 1) + (RW'(m3_ff[a]) <<< 1)
                   - (RW'(pe_ff[a]) <<< 30);
         magr_in[a] = r_in[a][RW-1] ? RW'(-r_in[a]) : RW'(r_in[a]);
         dprod_in[a] = d_ff[a] * d_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      // Stage A: address issue and centred offsets.
      inr_ff <= (ridx32 < 32'(WEIGHT_DEPTH));
      for (int a = 0; a < 3; a++) begin
         off_ff[a] <= off_in[a];
      end
      // Stage B: positions in Q.12 millimetres.
      wt_ff[1] <= inr_ff ? rd_ff : 16'd0;
      for (int a = 0; a < 3; a++) begin
         p_ff[a] <= $signed({1'b0, vox_ff[a]}) * off_ff[a];
      end
      // Stage C: products of the quaternion vector with the position.
      for (int a = 0; a < 3; a++) begin
         dd_ff[a] <= qu_ff[a] * p_ff[a];
         pc_ff[a] <= p_ff[a];
      end
      cxa_ff[0] <= qu_ff[1] * p_ff[2];
      cxb_ff[0] <= qu_ff[2] * p_ff[1];
      cxa_ff[1] <= qu_ff[2] * p_ff[0];
      cxb_ff[1] <= qu_ff[0] * p_ff[2];
      cxa_ff[2] <= qu_ff[0] * p_ff[1];
      cxb_ff[2] <= qu_ff[1] * p_ff[0];
      // Stage D: dot and cross products.
      dot_ff <= (UPW+2)'(dd_ff[0]) + (UPW+2)'(dd_ff[1]) + (UPW+2)'(dd_ff[2]);
      for (int a = 0; a < 3; a++) begin
         cr_ff[a] <= (UPW+1)'(cxa_ff[a]) - (UPW+1)'(cxb_ff[a]);
         pd_ff[a] <= pc_ff[a];
      end
      // Stage E: the three rotation terms.
      for (int a = 0; a < 3; a++) begin
         m1_ff[a] <= s2_ff * pd_ff[a];
         m2_ff[a] <= dot_ff * qu_ff[a];
         m3_ff[a] <= wq_ff * cr_ff[a];
         pe_ff[a] <= pd_ff[a];
      end
      // Stage F: displacement magnitude per axis in Q.16.
      for (int a = 0; a < 3; a++) begin
         d_ff[a] <= DW'(magr_in[a] >> 26);
      end
      // Stage G: squares, kept modulo 2^64.
      for (int a = 0; a < 3; a++) begin
         dq_ff[a] <= 64'(dprod_in[a]);
      end
      // Stage H: squared distance.
      dsq_ff <= dq_ff[0] + dq_ff[1] + dq_ff[2];
      for (int k = 2; k < 8; k++) begin
         wt_ff[k] <= wt_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // Square-root pipeline, shared by setup and by every voxel.
   always_comb begin
      sq_init.rad = inj_rad;
      sq_init.rem = '0;
      sq_init.root = '0;
   end

   always_ff @(posedge clock) begin
      sq_ff[0] <= wrmd_pkg::sqrt_step(sq_init);
      sqwt_ff[0] <= wt_ff[7];
      for (int k = 1; k < SQN; k++) begin
         sq_ff[k] <= wrmd_pkg::sqrt_step(sq_ff[k-1]);
         sqwt_ff[k] <= sqwt_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQN; k++) begin
            sqtag_ff[k] <= wrmd_pkg::SQ_NONE;
         end
      end else begin
         sqtag_ff[0] <= inj_tag;
         for (int k = 1; k < SQN; k++) begin
            sqtag_ff[k] <= sqtag_ff[k-1];
         end
      end
   end

   always_comb begin
      sq_busy = 1'b0;
      for (int k = 0; k < SQN; k++) begin
         sq_busy = sq_busy | (sqtag_ff[k] != wrmd_pkg::SQ_NONE);
      end
   end

   assign busy = (|vld_ff) || sq_busy || vi_ff;

   // ------------------------------------------------------------------
   // Weighted accumulation.
   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 1'b0;
      end else begin
         vi_ff <= (sqtag_ff[SQN-1] == wrmd_pkg::SQ_VOXEL);
      end
   end

   assign dsum65_in = {1'b0, dsum_ff} + 65'(term_ff);

   always_ff @(posedge clock) begin
      term_ff <= 48'(sqwt_ff[SQN-1]) * 48'(sq_ff[SQN-1].root);
      wti_ff <= sqwt_ff[SQN-1];
      if (state_ff == wrmd_pkg::ST_S2) begin
         dsum_ff <= '0;
         wsum_ff <= '0;
      end else if (vi_ff) begin
         dsum_ff <= dsum65_in[64] ? '1 : dsum65_in[63:0];
         wsum_ff <= wsum_ff + WSW'(wti_ff);
      end
   end

   // ------------------------------------------------------------------
   // Restoring divider, one quotient bit per cycle.
   assign rem_sh_in = {div_rem_ff, div_q_ff[63]};
   assign div_ge = (rem_sh_in >= {1'b0, wsum_ff});

   always_ff @(posedge clock) begin
      if (state_ff == wrmd_pkg::ST_DRAIN) begin
         div_q_ff <= dsum_ff;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == wrmd_pkg::ST_DIV) begin
         div_rem_ff <= div_ge ? WSW'(rem_sh_in - {1'b0, wsum_ff}) : WSW'(rem_sh_in);
         div_q_ff <= {div_q_ff[62:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
   end

   // ------------------------------------------------------------------
   // Output register.
   always_comb begin
      q32_in = (|div_q_ff[63:32]) ? 32'hFFFF_FFFF : div_q_ff[31:0];
      m33_in = {1'b0, q32_in} + {1'b0, tlen_ff};
      if (wsum_ff == '0) begin
         mean_in = tlen_ff;
      end else begin
         mean_in = m33_in[32] ? 32'hFFFF_FFFF : m33_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rspv_ff <= 1'b0;
      end else if (out_load) begin
         rspv_ff <= 1'b1;
      end else if (rsp_tready) begin
         rspv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_idx_ff <= rec_ff;
         out_tlen_ff <= tlen_ff;
         out_mean_ff <= mean_in;
         out_zero_ff <= (wsum_ff == '0);
      end
   end

   assign rsp_tvalid = rspv_ff;
   assign rsp_tuser = out_zero_ff;
   assign rsp_tdata = {out_mean_ff, out_tlen_ff, out_idx_ff};

endmodule

FILE: hdl/wrmd_checker.sv
// Port-level checks for the rigid-motion displacement block, bound to the top level.
module wrmd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wrmd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   logic [31:0] tlen_w, mean_w;

   assign tlen_w = rsp_tdata[wrmd_pkg::RSP_TLEN_LSB +: 32];
   assign mean_w = rsp_tdata[wrmd_pkg::RSP_MEAN_LSB +: 32];

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // With no weight the mean reports the translation alone.
   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> mean_w == tlen_w)
      else $error("zero-weight result differs from translation length");

   // The mean never falls below the translation length it includes.
   a_mean_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> mean_w >= tlen_w)
      else $error("mean displacement below translation length");

   // An evaluation occupies the block on the following cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == wrmd_pkg::OP_EVAL |=> !req_tready)
      else $error("ready right after an evaluation transaction");

endmodule

bind weighted_rigid_motion_displacement wrmd_checker u_wrmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the weighted rigid-motion displacement block.
`timescale 1ns / 100ps

typedef struct {
   bit               op;
   bit [17:0]        addr;
   bit [15:0]        wval;
   bit [15:0]        rec;
   bit signed [15:0] qx, qy, qz;
   bit               wneg;
   bit signed [23:0] sx, sy, sz;
} motion_req_type;

typedef struct {
   bit [15:0] index;
   bit [31:0] tlen;
   bit [31:0] mean;
   bit        zero_wt;
} motion_rsp_type;

class displacement_board;
   bit [15:0]      weights[int];
   bit [15:0]      regs[6];
   motion_rsp_type expected_q[$];
   int             fails;
   int             checked;

   function new();
      regs = '{64, 64, 64, 4096, 4096, 4096};
   endfunction

   function void set_reg(int idx, bit [15:0] val);
      regs[idx] = (idx < 3) ? (val & 16'h7F) : val;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function bit [63:0] root64(bit [63:0] n);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function bit [63:0] magn(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Records an accepted transaction; an evaluation gets its expected result queued.
   function void note_request(motion_req_type it);
      longint u[3], vox[3], p[3], cr[3], sh[3];
      longint s, wq, s2, dot, r;
      longint n[3];
      bit [63:0] t, tsq, tlen, wsum, dsum, dsq, d, vox_dist, term, mean, wt, idx;
      motion_rsp_type e;
      if (it.op == wrmd_pkg::OP_WRITE) begin
         weights[it.addr] = it.wval;
         return;
      end
      u = '{it.qx, it.qy, it.qz};
      sh = '{it.sx, it.sy, it.sz};
      for (int a = 0; a < 3; a++) begin
         vox[a] = regs[3 + a];
         n[a] = (regs[a] > 64) ? 64 : regs[a];
      end
      s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      wq = (s >= (64'sd1 <<< 30)) ? 0 : longint'(root64((64'sd1 <<< 30) - s));
      if (it.wneg) wq = -wq;
      tsq = 0;
      for (int a = 0; a < 3; a++) begin
         t = (magn(sh[a]) * vox[a]) >> 12;
         tsq += t * t;
      end
      tlen = root64(tsq);
      s2 = wq * wq - s;
      wsum = 0;
      dsum = 0;
      for (longint k = 0; k < n[2]; k++)
         for (longint j = 0; j < n[1]; j++)
            for (longint i = 0; i < n[0]; i++) begin
               idx = (k * n[1] + j) * n[0] + i;
               if (idx >= wrmd_pkg::WEIGHT_DEPTH_DEF) continue;
               wt = weights.exists(int'(idx)) ? weights[int'(idx)] : 0;
               p[0] = vox[0] * (i - n[0] / 2);
               p[1] = vox[1] * (j - n[1] / 2);
               p[2] = vox[2] * (k - n[2] / 2);
               dot = u[0] * p[0] + u[1] * p[1] + u[2] * p[2];
               cr[0] = u[1] * p[2] - u[2] * p[1];
               cr[1] = u[2] * p[0] - u[0] * p[2];
               cr[2] = u[0] * p[1] - u[1] * p[0];
               dsq = 0;
               for (int a = 0; a < 3; a++) begin
                  r = s2 * p[a] + 2 * dot * u[a] + 2 * wq * cr[a];
                  d = magn(r - p[a] * (64'sd1 <<< 30)) >> 26;
                  dsq += d * d;
               end
               vox_dist = root64(dsq);
               term = wt * vox_dist;
               dsum = (dsum > ~64'd0 - term) ? ~64'd0 : dsum + term;
               wsum += wt;
            end
      e.index = it.rec;
      e.tlen = tlen[31:0];
      if (wsum == 0) begin
         e.mean = tlen[31:0];
         e.zero_wt = 1;
      end else begin
         mean = dsum / wsum;
         if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
         mean += tlen;
         e.mean = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
         e.zero_wt = 0;
      end
      expected_q.push_back(e);
   endfunction

   function void check_result(bit [wrmd_pkg::RSP_TDATA_W-1:0] data, bit zw);
      motion_rsp_type e;
      if (expected_q.size() == 0) begin
         $error("result with no evaluation outstanding: tdata=%h", data);
         fails++;
         return;
      end
      e = expected_q.pop_front();
      checked++;
      if (data[15:0] !== e.index) begin
         $error("result_index: expected %0d, actual %0d", e.index, data[15:0]);
         fails++;
      end
      if (data[47:16] !== e.tlen) begin
         $error("translation_length: expected %0d, actual %0d", e.tlen, data[47:16]);
         fails++;
      end
      if (data[79:48] !== e.mean) begin
         $error("mean_displacement: expected %0d, actual %0d", e.mean, data[79:48]);
         fails++;
      end
      if (zw !== e.zero_wt) begin
         $error("zero_weight: expected %0d, actual %0d", e.zero_wt, zw);
         fails++;
      end
   endfunction
endclass

module tb_top;

   localparam int IDLE_LIMIT = 200000;
   localparam int DRAIN_WAIT = 300;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [wrmd_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [wrmd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_wen;
   logic [wrmd_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [wrmd_pkg::CSR_DATA_W-1:0]  csr_wdata;

   displacement_board board = new();
   int  idle_cycles;
   int  burst_left;
   bit  gaps_on;
   bit  hold_off;
   int  n_writes, n_evals;

   weighted_rigid_motion_displacement dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Result monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: switches between always ready and two stall densities; a long hold-off on request.
   initial begin
      int mode;
      mode = 0;
      rsp_tready <= 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   function automatic logic [wrmd_pkg::REQ_TDATA_W-1:0] pack(motion_req_type it);
      logic [wrmd_pkg::REQ_TDATA_W-1:0] v;
      v = '0;
      v[wrmd_pkg::F_ADDR_LSB +: 18] = it.addr;
      v[wrmd_pkg::F_WVAL_LSB +: 16] = it.wval;
      v[wrmd_pkg::F_REC_LSB +: 16]  = it.rec;
      v[wrmd_pkg::F_QX_LSB +: 16]   = it.qx;
      v[wrmd_pkg::F_QY_LSB +: 16]   = it.qy;
      v[wrmd_pkg::F_QZ_LSB +: 16]   = it.qz;
      v[wrmd_pkg::F_WNEG_LSB]       = it.wneg;
      v[wrmd_pkg::F_SX_LSB +: 24]   = it.sx;
      v[wrmd_pkg::F_SY_LSB +: 24]   = it.sy;
      v[wrmd_pkg::F_SZ_LSB +: 24]   = it.sz;
      return v;
   endfunction

   function automatic motion_req_type random_req(bit op);
      motion_req_type it;
      it.op = op;
      it.addr = 18'($urandom);
      it.wval = 16'($urandom);
      it.rec = 16'($urandom);
      it.qx = 16'($urandom);
      it.qy = 16'($urandom);
      it.qz = 16'($urandom);
      it.wneg = 1'($urandom);
      it.sx = 24'($urandom);
      it.sy = 24'($urandom);
      it.sz = 24'($urandom);
      // Mostly near-unit rotations so that w is rebuilt from a positive radicand.
      if ($urandom_range(0, 2) != 0) begin
         it.qx = 16'($signed(16'($urandom_range(0, 36000))) - 18000);
         it.qy = 16'($signed(16'($urandom_range(0, 36000))) - 18000);
         it.qz = 16'($signed(16'($urandom_range(0, 36000))) - 18000);
      end
      if ($urandom_range(0, 2) == 0) begin
         it.sx = 24'($signed(24'($urandom_range(0, 2000000))) - 1000000);
         it.sy = 24'($signed(24'($urandom_range(0, 2000000))) - 1000000);
         it.sz = 24'($signed(24'($urandom_range(0, 2000000))) - 1000000);
      end
      return it;
   endfunction

   task automatic send(motion_req_type it);
      req_tvalid <= 1;
      req_tdata  <= pack(it);
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      board.note_request(it);
      if (it.op == wrmd_pkg::OP_EVAL) n_evals++; else n_writes++;
      if (gaps_on && burst_left <= 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_config(bit [15:0] vals[6]);
      for (int i = 0; i < 6; i++) begin
         csr_wen   <= 1;
         csr_index <= wrmd_pkg::CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(i, vals[i]);
      end
      csr_wen <= 0;
      @(posedge clock);
   endtask

   // Every voxel of the walk must hold a written weight before an evaluation reads it.
   task automatic fill_weights(int count, bit zeros);
      motion_req_type it;
      for (int i = 0; i < count; i++)
         if (zeros || !board.weights.exists(i)) begin
            it = random_req(wrmd_pkg::OP_WRITE);
            it.addr = 18'(i);
            if (zeros) it.wval = 0;
            else if ($urandom_range(0, 4) == 0) it.wval = 0;
            send(it);
         end
   endtask

   function automatic motion_req_type eval_req(int qx, int qy, int qz, bit wneg,
                                               int sx, int sy, int sz, int rec);
      motion_req_type it;
      it = random_req(wrmd_pkg::OP_EVAL);
      it.qx = 16'(qx); it.qy = 16'(qy); it.qz = 16'(qz); it.wneg = wneg;
      it.sx = 24'(sx); it.sy = 24'(sy); it.sz = 24'(sz); it.rec = 16'(rec);
      return it;
   endfunction

   task automatic random_phase(bit [15:0] vals[6], int count, bit pause_mid, bit squeeze);
      int voxels;
      drain();
      set_config(vals);
      voxels = vals[0] * vals[1] * vals[2];
      fill_weights(voxels, 0);
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain();
         if (squeeze && i == 2) hold_off = 1;
         if (squeeze || $urandom_range(0, 1) == 1) begin
            send(random_req(wrmd_pkg::OP_EVAL));
         end else begin
            motion_req_type w;
            w = random_req(wrmd_pkg::OP_WRITE);
            // Keep most writes inside the walk so they change later results.
            if ($urandom_range(0, 2) != 0) w.addr = 18'($urandom_range(0, voxels - 1));
            send(w);
         end
      end
   endtask

   initial begin
      bit [15:0] cfg[6];
      reset      <= 1;
      req_tvalid <= 0;
      req_tdata  <= '0;
      req_tuser  <= wrmd_pkg::OP_WRITE;
      csr_wen    <= 0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      idle_cycles = 0;
      gaps_on = 0;
      burst_left = 0;
      hold_off = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part on a small grid.
      cfg = '{4, 3, 2, 4096, 4096, 4096};
      set_config(cfg);
      fill_weights(24, 0);
      send(eval_req(0, 0, 0, 0, 0, 0, 0, 0));
      send(eval_req(0, 0, 0, 1, 0, 0, 0, 16'hFFFF));
      send(eval_req(-32768, 0, 0, 0, 8388607, 0, 0, 1));         // radicand exactly zero
      send(eval_req(32767, 32767, 32767, 1, -8388608, -8388608, -8388608, 2)); // clamp w
      send(eval_req(0, -32768, 0, 1, 8388607, 8388607, 8388607, 3));
      send(eval_req(0, 0, 32767, 0, -1, 1, -65536, 4));
      send(eval_req(23170, 0, 0, 0, 65536, 0, 0, 5));           // 90 degrees about x
      send(eval_req(-23170, 0, 0, 1, 0, -65536, 0, 6));
      send(eval_req(0, 11585, -11585, 0, 32768, 32768, 32768, 7));
      begin
         motion_req_type w;
         w = random_req(wrmd_pkg::OP_WRITE);
         w.addr = 18'h3FFFF; w.wval = 16'hFFFF;
         send(w);
         w.addr = 18'd5; w.wval = 16'hFFFF;
         send(w);
         w.addr = 18'd0; w.wval = 16'd0;
         send(w);
      end
      send(eval_req(20000, -15000, 9000, 0, 1000, -2000, 3000, 8));

      // Random part with idle gaps, off for the third setting, across axis and voxel-size extremes.
      gaps_on = 1;
      cfg = '{64, 1, 1, 1, 65535, 300};
      random_phase(cfg, 5, 0, 0);
      cfg = '{1, 64, 1, 65535, 1, 4096};
      random_phase(cfg, 5, 1, 0);
      cfg = '{1, 1, 64, 8192, 20000, 1};
      gaps_on = 0;
      random_phase(cfg, 5, 0, 0);
      gaps_on = 1;
      cfg = '{1, 1, 1, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535))};
      random_phase(cfg, 5, 0, 0);
      cfg = '{5, 4, 3, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535))};
      random_phase(cfg, 5, 0, 1);

      // Weight total of zero, then a single nonzero weight.
      drain();
      cfg = '{2, 2, 2, 4096, 4096, 4096};
      set_config(cfg);
      fill_weights(8, 1);
      send(random_req(wrmd_pkg::OP_EVAL));
      send(eval_req(-32768, 0, 0, 0, 0, 0, 0, 9));
      begin
         motion_req_type w;
         w = random_req(wrmd_pkg::OP_WRITE);
         w.addr = 18'd7; w.wval = 16'd1;
         send(w);
      end
      send(random_req(wrmd_pkg::OP_EVAL));

      drain();
      $display("Covered %0d weight writes and %0d evaluations, %0d results checked,",
               n_writes, n_evals, board.checked);
      $display("over seven grid and voxel-size settings including a zero weight total.");
      if (board.fails == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: files.f
hdl/wrmd_pkg.sv
hdl/weighted_rigid_motion_displacement.sv
hdl/wrmd_checker.sv
dv/tb_top.sv
